// ----- design/assert_macros.svh -----
// Assertion macros used by the interval set merge table top level.
// Define ASSERT_OFF to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
`else
`define CHK_IMPLY(label, clk, rst, a, b)
`define CHK_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- design/ism_pkg.sv -----
// Package for the interval set merge table: operation codes, controller
// states and the command/status structs. No dependencies.
package ism_pkg;
  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_CONTAINS  = 3'd1;
  localparam logic [2:0] OP_INTERSECT = 3'd2;
  localparam logic [2:0] OP_SHIFT     = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  localparam logic [1:0] REG_MERGE_START   = 2'd0;
  localparam logic [1:0] REG_MERGE_END     = 2'd1;
  localparam logic [1:0] REG_COVERED_START = 2'd2;
  localparam logic [1:0] REG_COVERED_END   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COVER_RD, ST_COVER, ST_COUNT_RD, ST_COUNT, ST_MERGE_RD, ST_MERGE,
    ST_APPEND, ST_SECT_RD, ST_SECT, ST_SHIFT_RD, ST_SHIFT, ST_DONE
  } ism_state_t;

  typedef struct packed {
    logic load;      // latch the item
    logic rd;        // issue a memory read at the scan index
    logic scan_rst;  // restart the scan index and counters
    logic cover_chk; // evaluate containment on the read entry
    logic cnt_chk;   // count kept entries
    logic merge;     // fold or compact the read entry
    logic append;    // write the merged range
    logic sect;      // evaluate a cropped piece
    logic shift;     // write back a shifted entry
    logic clear;
  } ism_cmd_t;

  typedef struct packed {
    logic scan_end;  // scan index has reached the entry count
    logic hit;       // containment seen
    logic full;      // kept count reached capacity
  } ism_sts_t;
endpackage

// ----- design/interval_set_merge_table.sv -----
// Top level of the interval set merge table: ties controller and datapath.
// Depends on ism_pkg, ism_ctrl, ism_path and assert_macros.svh.
//
// Usage: raise start with operation and its operands; the item is taken at
// a clock edge where busy is low. The block holds up to ENTRIES disjoint
// intervals. Each result appears for one cycle with strobe high; the one that
// ends an item has last set. Intersect gives one result per cropped piece,
// or one with found low if there is none. An insert runs up to three scan
// passes (cover, count, merge), then an append and a done step; contains,
// intersect and shift run one scan pass, clear and unknown operations only
// the done step. The final result shows in the first cycle with busy low,
// and the next item may be taken in that same cycle.
// Results cannot be stalled; the receiver must take each strobe.
// Configuration: wr_en, wr_index, wr_data write one of the four 1-bit flags;
// write only while busy is low. Reset empties the table and sets every flag
// to 1; entry storage itself is not cleared.
`include "assert_macros.svh"
module interval_set_merge_table import ism_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [63:0] range_start,
  input  logic signed [63:0] range_end,
  input  logic               query_start_inclusive,
  input  logic               query_end_inclusive,
  input  logic signed [63:0] shift_amount,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic               wr_data,
  output logic               strobe,
  output logic               status,
  output logic               found,
  output logic signed [63:0] piece_start,
  output logic signed [63:0] piece_end,
  output logic               last,
  output logic [$clog2(ENTRIES+1)-1:0] entry_total
);
  ism_cmd_t cmd;
  ism_sts_t sts;
  logic fin;
  logic [3:0] cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= 4'hF;
    end else if (wr_en) begin
      cfg[wr_index] <= wr_data;
    end
  end

  ism_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation), .sts(sts),
    .busy(busy), .cmd(cmd), .fin(fin)
  );

  ism_path #(.ENTRIES(ENTRIES), .TIME_BITS(TIME_BITS)) u_path (
    .clk(clk), .rst(rst), .cmd(cmd), .fin(fin), .operation(operation),
    .range_start(range_start), .range_end(range_end),
    .query_start_inclusive(query_start_inclusive),
    .query_end_inclusive(query_end_inclusive), .shift_amount(shift_amount),
    .cfg(cfg), .sts(sts), .strobe(strobe), .status(status), .found(found),
    .piece_start(piece_start), .piece_end(piece_end), .last(last),
    .entry_total(entry_total)
  );

  `CHK_IMPLY(a_last_strobe, clk, rst, last && !strobe, 1'b1)
  `CHK_NEXT(a_fin_strobe, clk, rst, fin, strobe && last)
  `CHK_IMPLY(a_total_cap, clk, rst, 1'b1, entry_total <= ($clog2(ENTRIES+1))'(ENTRIES))
  `CHK_NEXT(a_start_busy, clk, rst, start && !busy, busy)
endmodule

// ----- design/ism_ctrl.sv -----
// Controller state machine for the interval set merge table.
// Depends on ism_pkg.
module ism_ctrl import ism_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] operation,
  input  ism_sts_t   sts,
  output logic       busy,
  output ism_cmd_t   cmd,
  output logic       fin
);
  ism_state_t state, state_next;
  logic [2:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (start && !busy) op <= operation;
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    fin = 1'b0;
    unique case (state)
      ST_IDLE: if (start) begin
        cmd.load = 1'b1;
        cmd.scan_rst = 1'b1;
        priority case (operation)
          OP_INSERT:    state_next = ST_COVER_RD;
          OP_CONTAINS:  state_next = ST_COVER_RD;
          OP_INTERSECT: state_next = ST_SECT_RD;
          OP_SHIFT:     state_next = ST_SHIFT_RD;
          OP_CLEAR:     begin cmd.clear = 1'b1; state_next = ST_DONE; end
          default:      state_next = ST_DONE;
        endcase
      end
      ST_COVER_RD: begin
        if (sts.scan_end || sts.hit) begin
          cmd.scan_rst = (op == OP_INSERT) && !sts.hit;
          state_next = (op == OP_INSERT && !sts.hit) ? ST_COUNT_RD : ST_DONE;
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_COVER;
        end
      end
      ST_COVER: begin cmd.cover_chk = 1'b1; state_next = ST_COVER_RD; end
      ST_COUNT_RD: begin
        if (sts.scan_end) begin
          // A full count is kept so the done cycle can flag the dropped insert.
          cmd.scan_rst = !sts.full;
          state_next = sts.full ? ST_DONE : ST_MERGE_RD;
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin cmd.cnt_chk = 1'b1; state_next = ST_COUNT_RD; end
      ST_MERGE_RD: begin
        if (sts.scan_end) begin
          state_next = ST_APPEND;
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin cmd.merge = 1'b1; state_next = ST_MERGE_RD; end
      ST_APPEND: begin cmd.append = 1'b1; state_next = ST_DONE; end
      ST_SECT_RD: begin
        if (sts.scan_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_SECT;
        end
      end
      ST_SECT: begin cmd.sect = 1'b1; state_next = ST_SECT_RD; end
      ST_SHIFT_RD: begin
        if (sts.scan_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.rd = 1'b1;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin cmd.shift = 1'b1; state_next = ST_SHIFT_RD; end
      ST_DONE: begin fin = 1'b1; state_next = ST_IDLE; end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ----- design/ism_path.sv -----
// Datapath of the interval set merge table: entry memory, scan index,
// comparators and result registers. Depends on ism_pkg.
module ism_path import ism_pkg::*; #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ism_cmd_t           cmd,
  input  logic               fin,
  input  logic [2:0]         operation,
  input  logic signed [63:0] range_start,
  input  logic signed [63:0] range_end,
  input  logic               query_start_inclusive,
  input  logic               query_end_inclusive,
  input  logic signed [63:0] shift_amount,
  input  logic [3:0]         cfg,
  output ism_sts_t           sts,
  output logic               strobe,
  output logic               status,
  output logic               found,
  output logic signed [63:0] piece_start,
  output logic signed [63:0] piece_end,
  output logic               last,
  output logic [$clog2(ENTRIES+1)-1:0] entry_total
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TW = TIME_BITS;
  localparam logic signed [TW-1:0] TMAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] TMIN = {1'b1, {(TW-1){1'b0}}};

  logic signed [TW-1:0] mem_b [ENTRIES];
  logic signed [TW-1:0] mem_f [ENTRIES];
  logic signed [TW-1:0] rd_b, rd_f, s, e;
  logic signed [TW-1:0] s_in, e_in;
  logic [2:0] op;
  logic qs, qe, hit, pend, sect_hit;
  logic signed [64:0] amt;
  logic [CW-1:0] idx, cnt, kept;
  logic signed [TW-1:0] p_s, p_e;

  function automatic logic signed [TW-1:0] clampt(input logic signed [63:0] v);
    logic signed [TW-1:0] r;
    r = v[TW-1:0];
    if (v > 64'(TMAX)) r = TMAX;
    else if (v < 64'(TMIN)) r = TMIN;
    return r;
  endfunction

  // Two extra bits hold the exact sum; the result is clamped back.
  function automatic logic signed [TW-1:0] sat_add(input logic signed [TW-1:0] a,
                                                   input logic signed [64:0] d);
    logic signed [65:0] t;
    logic signed [TW-1:0] r;
    t = 66'(a) + 66'(d);
    r = t[TW-1:0];
    if (t > 66'(TMAX)) r = TMAX;
    else if (t < 66'(TMIN)) r = TMIN;
    return r;
  endfunction

  assign s_in = clampt(range_start);
  assign e_in = clampt(range_end);

  logic ovl, cov, no_in, no_out, cs, ce;
  always_comb begin
    cs = (op == OP_CONTAINS) ? qs : cfg[REG_COVERED_START];
    ce = (op == OP_CONTAINS) ? qe : cfg[REG_COVERED_END];
    cov = (cs ? (s >= rd_b) : (s > rd_b)) && (ce ? (e <= rd_f) : (e < rd_f));
    no_in = cfg[REG_MERGE_START] ? (e < rd_b) : (e <= rd_b);
    no_out = cfg[REG_MERGE_END] ? (s > rd_f) : (s >= rd_f);
    ovl = !no_in && !no_out;
  end

  assign sect_hit = (rd_f > s) && (rd_b < e);

  assign sts.scan_end = (idx >= cnt) || (idx >= CW'(ENTRIES));
  assign sts.hit = hit;
  assign sts.full = (kept >= CW'(ENTRIES));

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_b <= mem_b[idx[IW-1:0]];
      rd_f <= mem_f[idx[IW-1:0]];
    end
    if (cmd.merge && !ovl) begin
      mem_b[kept[IW-1:0]] <= rd_b;
      mem_f[kept[IW-1:0]] <= rd_f;
    end else if (cmd.append) begin
      mem_b[kept[IW-1:0]] <= s;
      mem_f[kept[IW-1:0]] <= e;
    end else if (cmd.shift) begin
      mem_b[idx[IW-1:0] - 1'b1] <= sat_add(rd_b, amt);
      mem_f[idx[IW-1:0] - 1'b1] <= sat_add(rd_f, amt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      qs <= query_start_inclusive;
      qe <= query_end_inclusive;
      amt <= 65'(shift_amount);
      s <= (e_in < s_in) ? e_in : s_in;
      e <= (e_in < s_in) ? s_in : e_in;
    end else if (cmd.merge && ovl) begin
      if (rd_b < s) s <= rd_b;
      if (rd_f > e) e <= rd_f;
    end
    if (cmd.sect && sect_hit) begin
      p_s <= (rd_b > s) ? rd_b : s;
      p_e <= (rd_f < e) ? rd_f : e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; idx <= '0; kept <= '0; hit <= 1'b0; pend <= 1'b0;
      strobe <= 1'b0; status <= 1'b0; found <= 1'b0; last <= 1'b0;
      piece_start <= '0; piece_end <= '0;
    end else begin
      if (cmd.scan_rst) idx <= '0;
      else if (cmd.rd) idx <= idx + 1'b1;
      if (cmd.scan_rst) kept <= '0;
      else if ((cmd.cnt_chk || cmd.merge) && !ovl) kept <= kept + 1'b1;
      if (cmd.load) hit <= 1'b0;
      else if (cmd.cover_chk && cov) hit <= 1'b1;
      if (cmd.clear) cnt <= '0;
      else if (cmd.append) cnt <= kept + 1'b1;
      if (cmd.load) pend <= 1'b0;
      else if (cmd.sect && sect_hit) pend <= 1'b1;
      strobe <= fin || (cmd.sect && sect_hit && pend);
      // An intersect piece is held one step so the final one can carry last.
      if (fin) begin
        last <= 1'b1;
        status <= (op == OP_INSERT) && !hit && sts.full;
        found <= (op == OP_CONTAINS) ? hit : ((op == OP_INTERSECT) && pend);
        piece_start <= ((op == OP_INTERSECT) && pend) ? 64'(p_s) : '0;
        piece_end <= ((op == OP_INTERSECT) && pend) ? 64'(p_e) : '0;
      end else if (cmd.sect && sect_hit && pend) begin
        status <= 1'b0; found <= 1'b1; last <= 1'b0;
        piece_start <= 64'(p_s); piece_end <= 64'(p_e);
      end
    end
  end

  assign entry_total = cnt;
endmodule

// ----- sim/tb_interval_set_merge_table.sv -----
// Self-checking bench: a table model predicts every result, a monitor
// compares them field by field. Depends on interval_set_merge_table, ism_pkg.
module tb_interval_set_merge_table;
  import ism_pkg::*;

  localparam int SLOTS = 16;
  localparam longint TMAX = 64'sh7fffffffffffffff;
  localparam longint TMIN = 64'sh8000000000000000;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic [2:0]  op;
    longint      lo;
    longint      hi;
    bit          qs;
    bit          qe;
    longint      amt;
  } cmd_t;

  typedef struct {
    bit          status;
    bit          found;
    longint      ps;
    longint      pe;
    bit          last;
    int          total;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [2:0] operation = OP_CLEAR;
  logic signed [63:0] range_start = 0;
  logic signed [63:0] range_end = 0;
  logic query_start_inclusive = 0;
  logic query_end_inclusive = 0;
  logic signed [63:0] shift_amount = 0;
  logic wr_en = 0;
  logic [1:0] wr_index = REG_MERGE_START;
  logic wr_data = 0;
  logic strobe, status, found, last;
  logic signed [63:0] piece_start, piece_end;
  logic [4:0] entry_total;

  interval_set_merge_table u_top (
    .clk, .rst, .start, .busy, .operation, .range_start, .range_end,
    .query_start_inclusive, .query_end_inclusive, .shift_amount,
    .wr_en, .wr_index, .wr_data, .strobe, .status, .found,
    .piece_start, .piece_end, .last, .entry_total
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Table model.
  longint tbl_lo[SLOTS];
  longint tbl_hi[SLOTS];
  int     tbl_n = 0;
  bit     flag_ms = 1, flag_me = 1, flag_cs = 1, flag_ce = 1;

  cmd_t    pending[$];
  answer_t awaited[$];
  int      errors = 0;
  bit      quiet_tail = 0;
  bit      hold = 0;
  int      gap = 0;
  int      idle_cycles = 0;

  function automatic bit covered(longint s, longint e, bit si, bit ei);
    for (int i = 0; i < tbl_n; i++)
      if ((si ? s >= tbl_lo[i] : s > tbl_lo[i]) && (ei ? e <= tbl_hi[i] : e < tbl_hi[i]))
        return 1;
    return 0;
  endfunction

  function automatic bit touches(int i, longint s, longint e);
    bit no_in, no_out;
    no_in = flag_ms ? (e < tbl_lo[i]) : (e <= tbl_lo[i]);
    no_out = flag_me ? (s > tbl_hi[i]) : (s >= tbl_hi[i]);
    return !no_in && !no_out;
  endfunction

  function automatic longint sat_shift(longint a, longint s);
    if (s > 0 && a > TMAX - s) return TMAX;
    if (s < 0 && a < TMIN - s) return TMIN;
    return a + s;
  endfunction

  function automatic answer_t mk(bit st, bit fd, longint ps, longint pe, bit lst);
    answer_t a;
    a.status = st; a.found = fd; a.ps = ps; a.pe = pe; a.last = lst; a.total = tbl_n;
    return a;
  endfunction

  task automatic note_answer(answer_t a);
    awaited = {awaited, a};
  endtask

  task automatic apply_to_table(cmd_t c);
    longint s, e, t;
    int kept, n;
    bit drop;
    s = c.lo; e = c.hi;
    if (e < s) begin t = s; s = e; e = t; end
    case (c.op)
      OP_INSERT: begin
        drop = 0;
        if (!covered(s, e, flag_cs, flag_ce)) begin
          kept = 0;
          for (int i = 0; i < tbl_n; i++) if (!touches(i, s, e)) kept++;
          if (kept >= SLOTS) drop = 1;
          else begin
            kept = 0;
            for (int i = 0; i < tbl_n; i++) begin
              if (touches(i, s, e)) begin
                if (tbl_lo[i] < s) s = tbl_lo[i];
                if (tbl_hi[i] > e) e = tbl_hi[i];
              end else begin
                tbl_lo[kept] = tbl_lo[i]; tbl_hi[kept] = tbl_hi[i]; kept++;
              end
            end
            tbl_lo[kept] = s; tbl_hi[kept] = e; tbl_n = kept + 1;
          end
        end
        note_answer(mk(drop, 0, 0, 0, 1));
      end
      OP_CONTAINS: note_answer(mk(0, covered(s, e, c.qs, c.qe), 0, 0, 1));
      OP_INTERSECT: begin
        n = 0;
        for (int i = 0; i < tbl_n; i++) begin
          if (tbl_hi[i] <= s || tbl_lo[i] >= e) continue;
          note_answer(mk(0, 1, tbl_lo[i] > s ? tbl_lo[i] : s,
                         tbl_hi[i] < e ? tbl_hi[i] : e, 0));
          n++;
        end
        if (n == 0) note_answer(mk(0, 0, 0, 0, 1));
        else awaited[$].last = 1;
      end
      OP_SHIFT: begin
        for (int i = 0; i < tbl_n; i++) begin
          tbl_lo[i] = sat_shift(tbl_lo[i], c.amt);
          tbl_hi[i] = sat_shift(tbl_hi[i], c.amt);
        end
        note_answer(mk(0, 0, 0, 0, 1));
      end
      OP_CLEAR: begin
        tbl_n = 0;
        note_answer(mk(0, 0, 0, 0, 1));
      end
      default: note_answer(mk(0, 0, 0, 0, 1));
    endcase
  endtask

  // Driver: a transfer happens at an edge with start high and busy low.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        apply_to_table('{operation, range_start, range_end,
                         query_start_inclusive, query_end_inclusive, shift_amount});
        pending.pop_front();
      end
      if (start && !busy) begin
        if (pending.size() > 0 && !hold && ($urandom_range(0, 5) != 0 || quiet_tail)) begin
          operation <= pending[0].op; range_start <= pending[0].lo;
          range_end <= pending[0].hi; query_start_inclusive <= pending[0].qs;
          query_end_inclusive <= pending[0].qe; shift_amount <= pending[0].amt;
        end else begin
          start <= 0;
          gap <= quiet_tail ? 0 : $urandom_range(1, 7);
        end
      end else if (!start) begin
        if (gap > 0) gap <= gap - 1;
        else if (pending.size() > 0 && !hold) begin
          start <= 1;
          operation <= pending[0].op; range_start <= pending[0].lo;
          range_end <= pending[0].hi; query_start_inclusive <= pending[0].qs;
          query_end_inclusive <= pending[0].qe; shift_amount <= pending[0].amt;
        end
      end
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    answer_t w;
    if (!rst) begin
      if (strobe) begin
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d found=%0d", $time, status, found);
        end else begin
          w = awaited.pop_front();
          if (status !== w.status || found !== w.found || piece_start !== w.ps ||
              piece_end !== w.pe || last !== w.last || entry_total !== w.total) begin
            errors++;
            $display("%0t: expected st=%0d fd=%0d ps=%0d pe=%0d last=%0d total=%0d",
                     $time, w.status, w.found, w.ps, w.pe, w.last, w.total);
            $display("%0t:   actual st=%0d fd=%0d ps=%0d pe=%0d last=%0d total=%0d",
                     $time, status, found, piece_start, piece_end, last, entry_total);
          end
        end
      end
      if (strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic longint rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic longint pick_tick();
    case ($urandom_range(0, 9))
      0: return TMAX;
      1: return TMIN;
      2: return rand64();
      default: return longint'($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  task automatic queue_cmd(logic [2:0] op, longint lo, longint hi, bit qs, bit qe,
                           longint amt);
    cmd_t c;
    c = '{op, lo, hi, qs, qe, amt};
    pending = {pending, c};
  endtask

  task automatic queue_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_cmd(OP_INSERT, pick_tick(), pick_tick(), 1'($urandom), 1'($urandom),
                  rand64());
      end else if (r < 62) begin
        queue_cmd(OP_CONTAINS, pick_tick(), pick_tick(), 1'($urandom), 1'($urandom),
                  rand64());
      end else if (r < 82) begin
        queue_cmd(OP_INTERSECT, pick_tick(), pick_tick(), 1'($urandom), 1'($urandom),
                  rand64());
      end else if (r < 94) begin
        queue_cmd(OP_SHIFT, rand64(), rand64(), 1'($urandom), 1'($urandom),
                  $urandom_range(0, 3) == 0 ? rand64()
                                            : longint'($urandom_range(0, 60)) - 30);
      end else if (r < 97) begin
        queue_cmd(OP_CLEAR, rand64(), rand64(), 1'($urandom), 1'($urandom), rand64());
      end else begin
        queue_cmd(3'($urandom_range(5, 7)), rand64(), rand64(), 1'($urandom),
                  1'($urandom), rand64());
      end
    end
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || start || busy || awaited.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_flags(bit [3:0] v);
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      wr_en <= 1; wr_index <= 2'(i); wr_data <= v[i];
    end
    @(posedge clk);
    wr_en <= 0;
    flag_ms = v[0]; flag_me = v[1]; flag_cs = v[2]; flag_ce = v[3];
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    // Directed: touching bounds, containment, extremes, full table, saturation.
    queue_cmd(OP_INTERSECT, 0, 10, 0, 0, 0);
    queue_cmd(OP_INSERT, 10, 0, 0, 0, 0);
    queue_cmd(OP_INSERT, 10, 20, 0, 0, 0);
    queue_cmd(OP_INSERT, 2, 5, 0, 0, 0);
    queue_cmd(OP_CONTAINS, 0, 20, 1, 1, 0);
    queue_cmd(OP_CONTAINS, 0, 20, 0, 0, 0);
    queue_cmd(OP_INSERT, TMIN, TMIN + 3, 0, 0, 0);
    queue_cmd(OP_INSERT, TMAX - 3, TMAX, 0, 0, 0);
    queue_cmd(OP_INTERSECT, TMAX, TMIN, 0, 0, 0);
    queue_cmd(OP_SHIFT, 0, 0, 0, 0, TMAX);
    queue_cmd(OP_SHIFT, 0, 0, 0, 0, TMIN);
    queue_cmd(OP_INTERSECT, TMIN, TMAX, 1, 1, 0);
    queue_cmd(3'd7, -1, -1, 1, 1, -1);
    queue_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) queue_cmd(OP_INSERT, i * 10, i * 10 + 3, 0, 0, 0);
    queue_cmd(OP_INTERSECT, 0, 200, 0, 0, 0);
    queue_cmd(OP_INSERT, 0, 200, 0, 0, 0);
    wait_drained();
    // Random phases over several flag settings, extremes included.
    write_flags(4'b0000);
    queue_random(60);
    wait_drained();
    write_flags(4'b0101);
    queue_random(50);
    // Sender holds until every expected result has come in.
    wait (pending.size() == 0);
    hold = 1;
    wait_drained();
    hold = 0;
    write_flags(4'b1010);
    queue_random(50);
    wait_drained();
    write_flags(4'b1111);
    quiet_tail = 0;
    queue_random(67);
    wait (pending.size() < 20);
    quiet_tail = 1;
    wait_drained();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/ism_pkg.sv
design/ism_ctrl.sv
design/ism_path.sv
design/interval_set_merge_table.sv
sim/tb_interval_set_merge_table.sv
